FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on the rising edge, off during reset
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on the rising edge, off during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/i2cmte_pkg.sv
`timescale 1ns / 1ps

package i2cmte_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_HALF_PERIOD   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_STRETCH_LIMIT = 2'd1;

    localparam logic [15:0] HALF_PERIOD_RESET   = 16'd10;
    localparam logic [7:0]  STRETCH_LIMIT_RESET = 8'd100;

    // command codes
    localparam logic [1:0] CMD_TICK         = 2'd0;
    localparam logic [1:0] CMD_WRITE_STOP   = 2'd1;
    localparam logic [1:0] CMD_WRITE_RSTART = 2'd2;
    localparam logic [1:0] CMD_READ         = 2'd3;

    localparam logic [3:0] BITS_PER_BYTE = 4'd8;

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_START_SCL,
        PH_OUT_SETUP,
        PH_ACKCHK_SETUP,
        PH_IN_SETUP,
        PH_ACKSEND_SETUP,
        PH_RELEASE,
        PH_POLL,
        PH_STOP_A,
        PH_STOP_B,
        PH_STOP_C,
        PH_FINISH
    } t_phase;

    typedef enum logic [2:0] {
        ROLE_ADDR,
        ROLE_WDATA,
        ROLE_ACKCHK,
        ROLE_RDATA,
        ROLE_ACKSEND
    } t_role;

    typedef struct packed {
        logic [1:0] command;
        logic [6:0] target_address;
        logic [7:0] byte_count;
        logic [7:0] write_data;
        logic       scl_sense;
        logic       sda_sense;
    } t_in_beat;

    typedef struct packed {
        logic       scl_pull_low;
        logic       sda_pull_low;
        logic       busy_res;
        logic       write_taken;
        logic       read_valid;
        logic [7:0] read_data;
        logic       done_res;
        logic       status;
        logic       stretch_timeout;
    } t_out_beat;

    typedef struct packed {
        t_phase      phase;
        logic [15:0] delay_count;
        logic [7:0]  poll_count;
        logic [7:0]  shift_byte;
        logic [3:0]  bit_index;
        logic [7:0]  bytes_left;
        logic [1:0]  transaction_kind;
        logic        scl_driven_low;
        logic        sda_driven_low;
        logic        ack_failed;
        t_role       bit_role;
    } t_state;

    localparam t_state STATE_RESET = '{
        phase:            PH_IDLE,
        delay_count:      16'd0,
        poll_count:       8'd0,
        shift_byte:       8'd0,
        bit_index:        4'd0,
        bytes_left:       8'd0,
        transaction_kind: 2'd0,
        scl_driven_low:   1'b0,
        sda_driven_low:   1'b0,
        ack_failed:       1'b0,
        bit_role:         ROLE_ADDR
    };

endpackage

FILE: src/i2c_master_transaction_engine_unit.sv
`timescale 1ns / 1ps
// i2c master transaction engine, one timing tick per input beat
// input channel (i_in_valid / o_in_ready / i_in_data): each beat is one tick,
//   carrying a command (taken only when idle), address, byte count, the next
//   write byte and the sampled scl and sda line levels
// output channel (o_out_valid / i_out_ready / o_out_data): exactly one result
//   beat per input beat, in order: open-drain pin drives, busy, write byte
//   taken, received byte, done and status, stretch timeout
// config port: i_cfg_we with i_cfg_index 0 sets the half period in ticks,
//   index 1 sets the scl stretch poll limit; other indexes are ignored
// timing: a beat's result is registered and shows on the output in the cycle after the
//   beat is accepted; one beat per cycle is sustained while the receiver is ready, set by
//   the single step stage between the state registers and the result register
// a stalled receiver holds the result register and the input waits with it;
//   input is taken again in the cycle the held result leaves, so a stall
//   adds no bubble beyond its own length
// reset: idle, both lines released, half period 10, poll limit 100,
//   output register empty

`include "assert_macros.svh"

module i2c_master_transaction_engine_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  i2cmte_pkg::t_in_beat                i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output i2cmte_pkg::t_out_beat               o_out_data,
    input  logic                                i_cfg_we,
    input  logic [i2cmte_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [i2cmte_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import i2cmte_pkg::*;

    // engine state and configuration
    t_state      r_state;
    t_state      n_state;
    logic [15:0] r_half_period;
    logic [7:0]  r_poll_limit;

    // result register
    logic        r_out_valid;
    t_out_beat   r_out_data;
    t_out_beat   n_out_data;

    logic        in_beat;

    // free slot, or the held result leaves this cycle
    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_beat    = i_in_valid && o_in_ready;

    i2cmte_step u_step (
        .i_state       (r_state),
        .i_half_period (r_half_period),
        .i_poll_limit  (r_poll_limit),
        .i_in          (i_in_data),
        .o_state       (n_state),
        .o_out         (n_out_data)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= HALF_PERIOD_RESET;
            r_poll_limit  <= STRETCH_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_HALF_PERIOD:   r_half_period <= i_cfg_data;
                CFG_STRETCH_LIMIT: r_poll_limit  <= i_cfg_data[7:0];
                default:           r_poll_limit  <= r_poll_limit;
            endcase
        end
    end

    // engine state advances once per accepted tick
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= STATE_RESET;
        end else if (in_beat) begin
            r_state <= n_state;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (in_beat) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    `ASSERT_NEXT(a_beat_gives_result, i_clk, i_rst_n, in_beat, r_out_valid,
        "accepted beat lost its result")
    `ASSERT_IMPLY(a_stall_blocks_input, i_clk, i_rst_n, r_out_valid && !i_out_ready,
        !o_in_ready, "input taken over a held result")
    `ASSERT_IMPLY(a_idle_lines_free, i_clk, i_rst_n, r_state.phase == PH_IDLE,
        !r_state.scl_driven_low && !r_state.sda_driven_low, "idle engine still pulls a line")
    `ASSERT_IMPLY(a_done_not_busy, i_clk, i_rst_n, r_out_valid && r_out_data.done_res,
        !r_out_data.busy_res, "done beat still reports busy")
    `ASSERT_IMPLY(a_status_on_done, i_clk, i_rst_n, r_out_valid && r_out_data.status,
        r_out_data.done_res, "status set outside the done beat")

endmodule

FILE: src/i2cmte_step.sv
`timescale 1ns / 1ps

module i2cmte_step (
    input  i2cmte_pkg::t_state    i_state,
    input  logic [15:0]           i_half_period,
    input  logic [7:0]            i_poll_limit,
    input  i2cmte_pkg::t_in_beat  i_in,
    output i2cmte_pkg::t_state    o_state,
    output i2cmte_pkg::t_out_beat o_out
);
    import i2cmte_pkg::*;

    logic       act;
    logic [7:0] poll_inc;
    logic       poll_timeout;
    logic       bit_done;
    logic [3:0] idx_inc;
    logic       byte_full;
    t_phase     fin_phase;
    t_phase     n_phase;
    t_state     ns;

    // an action tick: busy and the wait has run out
    assign act          = (i_state.phase != PH_IDLE) && (i_state.delay_count == 16'd0);
    assign poll_inc     = i_state.poll_count + 8'd1;
    assign poll_timeout = act && (i_state.phase == PH_POLL) && !i_in.scl_sense
                          && (poll_inc >= i_poll_limit);
    assign bit_done     = act && (i_state.phase == PH_POLL)
                          && (i_in.scl_sense || poll_timeout);
    assign idx_inc      = i_state.bit_index + 4'd1;
    assign byte_full    = (idx_inc >= BITS_PER_BYTE);

    // phase that follows a completed bit
    always_comb begin
        case (i_state.bit_role)
            ROLE_ADDR, ROLE_WDATA: begin
                fin_phase = byte_full ? PH_ACKCHK_SETUP : PH_OUT_SETUP;
            end
            ROLE_ACKCHK: begin
                if (i_in.sda_sense || (i_state.bytes_left == 8'd0)) begin
                    fin_phase = PH_STOP_A;
                end else if (i_state.transaction_kind == CMD_READ) begin
                    fin_phase = PH_IN_SETUP;
                end else begin
                    fin_phase = PH_OUT_SETUP;
                end
            end
            ROLE_RDATA: begin
                fin_phase = byte_full ? PH_ACKSEND_SETUP : PH_IN_SETUP;
            end
            default: begin
                fin_phase = (i_state.bytes_left != 8'd0) ? PH_IN_SETUP : PH_STOP_A;
            end
        endcase
    end

    // next phase
    always_comb begin
        n_phase = i_state.phase;
        if (i_state.phase == PH_IDLE) begin
            if (i_in.command != CMD_TICK) begin
                n_phase = PH_START_SCL;
            end
        end else if (act) begin
            case (i_state.phase)
                PH_START_SCL:     n_phase = PH_OUT_SETUP;
                PH_OUT_SETUP:     n_phase = PH_RELEASE;
                PH_ACKCHK_SETUP:  n_phase = PH_RELEASE;
                PH_IN_SETUP:      n_phase = PH_RELEASE;
                PH_ACKSEND_SETUP: n_phase = PH_RELEASE;
                PH_RELEASE:       n_phase = PH_POLL;
                PH_POLL: begin
                    if (bit_done) begin
                        n_phase = fin_phase;
                    end
                end
                PH_STOP_A: n_phase = PH_STOP_B;
                PH_STOP_B: begin
                    n_phase = (i_state.transaction_kind == CMD_WRITE_RSTART) ?
                              PH_FINISH : PH_STOP_C;
                end
                PH_STOP_C: n_phase = PH_FINISH;
                PH_FINISH: n_phase = PH_IDLE;
                default:   n_phase = PH_IDLE;
            endcase
        end
    end

    // datapath and result fields
    always_comb begin
        ns    = i_state;
        o_out = '0;
        if (i_state.phase == PH_IDLE) begin
            if (i_in.command != CMD_TICK) begin
                ns.transaction_kind = i_in.command;
                ns.ack_failed       = 1'b0;
                ns.bytes_left       = i_in.byte_count;
                ns.shift_byte       = {i_in.target_address, i_in.command == CMD_READ};
                ns.bit_index        = 4'd0;
                ns.bit_role         = ROLE_ADDR;
                ns.sda_driven_low   = 1'b1;
                ns.delay_count      = i_half_period;
            end
        end else if (!act) begin
            ns.delay_count = i_state.delay_count - 16'd1;
        end else begin
            ns.delay_count = i_half_period;
            case (i_state.phase)
                PH_START_SCL: ns.scl_driven_low = 1'b1;
                PH_OUT_SETUP: begin
                    if ((i_state.bit_role == ROLE_WDATA) && (i_state.bit_index == 4'd0)) begin
                        ns.shift_byte     = i_in.write_data;
                        o_out.write_taken = 1'b1;
                    end
                    ns.sda_driven_low = !ns.shift_byte[7];
                end
                PH_ACKCHK_SETUP, PH_IN_SETUP: ns.sda_driven_low = 1'b0;
                PH_ACKSEND_SETUP: ns.sda_driven_low = (i_state.bytes_left != 8'd0);
                PH_RELEASE: begin
                    ns.scl_driven_low = 1'b0;
                    ns.poll_count     = 8'd0;
                end
                PH_POLL: begin
                    if (!i_in.scl_sense) begin
                        ns.poll_count = poll_inc;
                    end
                    o_out.stretch_timeout = poll_timeout;
                    if (bit_done) begin
                        ns.scl_driven_low = 1'b1;
                        case (i_state.bit_role)
                            ROLE_ADDR, ROLE_WDATA: begin
                                ns.shift_byte = {i_state.shift_byte[6:0], 1'b0};
                                ns.bit_index  = idx_inc;
                                if (byte_full) begin
                                    ns.bit_role = ROLE_ACKCHK;
                                end
                            end
                            ROLE_ACKCHK: begin
                                if (i_in.sda_sense) begin
                                    ns.ack_failed = 1'b1;
                                end else if (i_state.bytes_left == 8'd0) begin
                                    ns.ack_failed = i_state.ack_failed;
                                end else if (i_state.transaction_kind == CMD_READ) begin
                                    ns.bit_role   = ROLE_RDATA;
                                    ns.bit_index  = 4'd0;
                                    ns.shift_byte = 8'd0;
                                end else begin
                                    ns.bytes_left = i_state.bytes_left - 8'd1;
                                    ns.bit_role   = ROLE_WDATA;
                                    ns.bit_index  = 4'd0;
                                end
                            end
                            ROLE_RDATA: begin
                                ns.shift_byte = {i_state.shift_byte[6:0], i_in.sda_sense};
                                ns.bit_index  = idx_inc;
                                if (byte_full) begin
                                    o_out.read_valid = 1'b1;
                                    o_out.read_data  = ns.shift_byte;
                                    ns.bytes_left    = i_state.bytes_left - 8'd1;
                                    ns.bit_role      = ROLE_ACKSEND;
                                end
                            end
                            default: begin
                                if (i_state.bytes_left != 8'd0) begin
                                    ns.bit_role   = ROLE_RDATA;
                                    ns.bit_index  = 4'd0;
                                    ns.shift_byte = 8'd0;
                                end
                            end
                        endcase
                    end
                end
                PH_STOP_A: begin
                    ns.sda_driven_low = (i_state.transaction_kind != CMD_WRITE_RSTART);
                end
                PH_STOP_B: ns.scl_driven_low = 1'b0;
                PH_STOP_C: ns.sda_driven_low = 1'b0;
                PH_FINISH: begin
                    ns.delay_count = i_state.delay_count;
                    o_out.done_res = 1'b1;
                    o_out.status   = i_state.ack_failed;
                end
                default: ns.delay_count = i_state.delay_count;
            endcase
        end
        ns.phase           = n_phase;
        o_out.scl_pull_low = ns.scl_driven_low;
        o_out.sda_pull_low = ns.sda_driven_low;
        o_out.busy_res     = (n_phase != PH_IDLE);
    end

    assign o_state = ns;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
    import i2cmte_pkg::*;

    // longest run of cycles with no beat moving on either channel
    // the slowest correct run goes quiet only for a settle, two register writes
    // and the final drain
    localparam int QUIET_LIMIT = 1000;
    localparam int DRAIN_CYCLES = 16;
    localparam int RANDOM_TICKS = 100;
    localparam int IN_BITS = $bits(t_in_beat);

    // what the emulated slave puts on the data line and the write byte field
    typedef enum logic [1:0] {
        FILL_RANDOM,
        FILL_ZEROS,
        FILL_ONES
    } t_fill;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    t_in_beat i_in_data = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out_beat o_out_data;
    logic i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    // predicted result beats, oldest first
    t_out_beat expected_bus_beats[$];
    int mismatches = 0;
    int quiet_cycles = 0;
    int transaction_ticks = 0;
    // while set, neither side inserts idle cycles
    bit no_idle = 1'b0;

    // engine copy kept by the testbench
    logic [15:0] half_period;
    logic [7:0] poll_limit;
    t_phase bus_phase;
    t_role bus_role;
    logic [15:0] wait_left;
    logic [7:0] polls_seen;
    logic [7:0] shifter;
    logic [3:0] bit_pos;
    logic [7:0] bytes_to_go;
    logic [1:0] xfer_kind;
    logic scl_held_low;
    logic sda_held_low;
    logic got_nack;

    i2c_master_transaction_engine_unit DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // engine prediction
    // ------------------------------------------------------------------

    function automatic void reset_engine();
        half_period  = HALF_PERIOD_RESET;
        poll_limit   = STRETCH_LIMIT_RESET;
        bus_phase    = PH_IDLE;
        bus_role     = ROLE_ADDR;
        wait_left    = '0;
        polls_seen   = '0;
        shifter      = '0;
        bit_pos      = '0;
        bytes_to_go  = '0;
        xfer_kind    = CMD_TICK;
        scl_held_low = 1'b0;
        sda_held_low = 1'b0;
        got_nack     = 1'b0;
    endfunction

    // scl is driven low again after the sampled bit; decide what comes next
    function automatic void close_bit(input logic sda_level, inout t_out_beat r);
        scl_held_low = 1'b1;
        wait_left = half_period;
        case (bus_role)
            ROLE_ADDR, ROLE_WDATA: begin
                shifter = {shifter[6:0], 1'b0};
                bit_pos = bit_pos + 4'd1;
                if (bit_pos >= BITS_PER_BYTE) begin
                    bus_role = ROLE_ACKCHK;
                    bus_phase = PH_ACKCHK_SETUP;
                end else begin
                    bus_phase = PH_OUT_SETUP;
                end
            end
            ROLE_ACKCHK: begin
                if (sda_level) begin
                    // slave did not acknowledge, go straight to the ending
                    got_nack = 1'b1;
                    bus_phase = PH_STOP_A;
                end else if (bytes_to_go == 8'd0) begin
                    bus_phase = PH_STOP_A;
                end else if (xfer_kind == CMD_READ) begin
                    bus_role = ROLE_RDATA;
                    bit_pos = '0;
                    shifter = '0;
                    bus_phase = PH_IN_SETUP;
                end else begin
                    bytes_to_go = bytes_to_go - 8'd1;
                    bus_role = ROLE_WDATA;
                    bit_pos = '0;
                    bus_phase = PH_OUT_SETUP;
                end
            end
            ROLE_RDATA: begin
                shifter = {shifter[6:0], sda_level};
                bit_pos = bit_pos + 4'd1;
                if (bit_pos >= BITS_PER_BYTE) begin
                    r.read_valid = 1'b1;
                    r.read_data = shifter;
                    bytes_to_go = bytes_to_go - 8'd1;
                    bus_role = ROLE_ACKSEND;
                    bus_phase = PH_ACKSEND_SETUP;
                end else begin
                    bus_phase = PH_IN_SETUP;
                end
            end
            default: begin
                // master ack or nack just went out
                if (bytes_to_go != 8'd0) begin
                    bus_role = ROLE_RDATA;
                    bit_pos = '0;
                    shifter = '0;
                    bus_phase = PH_IN_SETUP;
                end else begin
                    bus_phase = PH_STOP_A;
                end
            end
        endcase
    endfunction

    // advance the engine copy by one tick and return the result beat it gives
    function automatic t_out_beat tick_engine(input t_in_beat tk);
        t_out_beat r;
        r = '0;
        if (bus_phase == PH_IDLE) begin
            // commands are only looked at while idle
            if (tk.command != CMD_TICK) begin
                xfer_kind = tk.command;
                got_nack = 1'b0;
                bytes_to_go = tk.byte_count;
                shifter = {tk.target_address, tk.command == CMD_READ};
                bit_pos = '0;
                bus_role = ROLE_ADDR;
                sda_held_low = 1'b1;
                wait_left = half_period;
                bus_phase = PH_START_SCL;
            end
        end else if (wait_left != 16'd0) begin
            wait_left = wait_left - 16'd1;
        end else begin
            case (bus_phase)
                PH_START_SCL: begin
                    scl_held_low = 1'b1;
                    wait_left = half_period;
                    bus_phase = PH_OUT_SETUP;
                end
                PH_OUT_SETUP: begin
                    // first bit of a data byte loads the byte from this tick
                    if (bus_role == ROLE_WDATA && bit_pos == 4'd0) begin
                        shifter = tk.write_data;
                        r.write_taken = 1'b1;
                    end
                    sda_held_low = !shifter[7];
                    wait_left = half_period;
                    bus_phase = PH_RELEASE;
                end
                PH_ACKCHK_SETUP, PH_IN_SETUP: begin
                    sda_held_low = 1'b0;
                    wait_left = half_period;
                    bus_phase = PH_RELEASE;
                end
                PH_ACKSEND_SETUP: begin
                    // ack while more bytes follow, nack on the last
                    sda_held_low = (bytes_to_go != 8'd0);
                    wait_left = half_period;
                    bus_phase = PH_RELEASE;
                end
                PH_RELEASE: begin
                    scl_held_low = 1'b0;
                    polls_seen = '0;
                    wait_left = half_period;
                    bus_phase = PH_POLL;
                end
                PH_POLL: begin
                    if (tk.scl_sense) begin
                        close_bit(tk.sda_sense, r);
                    end else begin
                        // slave stretches the clock
                        polls_seen = polls_seen + 8'd1;
                        if (polls_seen >= poll_limit) begin
                            r.stretch_timeout = 1'b1;
                            close_bit(tk.sda_sense, r);
                        end else begin
                            wait_left = half_period;
                        end
                    end
                end
                PH_STOP_A: begin
                    sda_held_low = (xfer_kind != CMD_WRITE_RSTART);
                    wait_left = half_period;
                    bus_phase = PH_STOP_B;
                end
                PH_STOP_B: begin
                    scl_held_low = 1'b0;
                    wait_left = half_period;
                    bus_phase = (xfer_kind == CMD_WRITE_RSTART) ? PH_FINISH : PH_STOP_C;
                end
                PH_STOP_C: begin
                    sda_held_low = 1'b0;
                    wait_left = half_period;
                    bus_phase = PH_FINISH;
                end
                PH_FINISH: begin
                    r.done_res = 1'b1;
                    r.status = got_nack;
                    bus_phase = PH_IDLE;
                end
                default: begin
                    bus_phase = PH_IDLE;
                end
            endcase
        end
        r.scl_pull_low = scl_held_low;
        r.sda_pull_low = sda_held_low;
        r.busy_res = (bus_phase != PH_IDLE);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // result checking
    // ------------------------------------------------------------------

    function automatic void check_field(input string field, input logic [7:0] want,
                                        input logic [7:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatches++;
        end
    endfunction

    // every result beat is matched against the oldest prediction
    always @(posedge i_clk) begin
        t_out_beat want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_bus_beats.size() == 0) begin
                $error("result beat arrived with none expected");
                mismatches++;
            end else begin
                want = expected_bus_beats.pop_front();
                check_field("scl_pull_low", want.scl_pull_low, o_out_data.scl_pull_low);
                check_field("sda_pull_low", want.sda_pull_low, o_out_data.sda_pull_low);
                check_field("busy_res", want.busy_res, o_out_data.busy_res);
                check_field("write_taken", want.write_taken, o_out_data.write_taken);
                check_field("read_valid", want.read_valid, o_out_data.read_valid);
                check_field("read_data", want.read_data, o_out_data.read_data);
                check_field("done_res", want.done_res, o_out_data.done_res);
                check_field("status", want.status, o_out_data.status);
                check_field("stretch_timeout", want.stretch_timeout,
                            o_out_data.stretch_timeout);
            end
        end
    end

    // receiver stalls about a quarter of the cycles unless told not to
    always @(posedge i_clk) begin
        i_out_ready <= no_idle || ($urandom_range(99) >= 25);
    end

    // watchdog: too long with no beat moving on either side
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= QUIET_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // one tick beat: optional idle gap, then hold valid until accepted
    task automatic send_tick(input t_in_beat tk);
        while (!no_idle && $urandom_range(99) < 25) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= tk;
        do @(posedge i_clk); while (!o_in_ready);
        expected_bus_beats.push_back(tick_engine(tk));
    endtask

    // stop sending and wait for every predicted beat to come back
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (expected_bus_beats.size() != 0);
    endtask

    // register writes only happen with nothing in flight
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] val);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_HALF_PERIOD) begin
            half_period = val;
        end else if (idx == CFG_STRETCH_LIMIT) begin
            poll_limit = val[7:0];
        end
        @(posedge i_clk);
    endtask

    // tick beat with no command, everything else random
    task automatic send_noise_tick();
        t_in_beat tk;
        tk = IN_BITS'($urandom);
        tk.command = CMD_TICK;
        send_tick(tk);
    endtask

    task automatic begin_transaction(input logic [1:0] cmd, input logic [6:0] addr,
                                     input logic [7:0] count);
        t_in_beat tk;
        tk = IN_BITS'($urandom);
        tk.command = cmd;
        tk.target_address = addr;
        tk.byte_count = count;
        send_tick(tk);
        transaction_ticks++;
    endtask

    // emulated slave: acks unless nack_pct says otherwise, stretches scl on
    // stretch_pct of the polls; busy_pct of the beats carry a stray command
    task automatic drive_until_idle(input int nack_pct, input int stretch_pct,
                                    input int busy_pct, input t_fill fill);
        t_in_beat tk;
        while (bus_phase != PH_IDLE) begin
            tk = IN_BITS'($urandom);
            tk.command = ($urandom_range(99) < busy_pct) ?
                         2'($urandom_range(CMD_WRITE_STOP, CMD_READ)) : CMD_TICK;
            if (fill == FILL_ONES) begin
                tk.write_data = 8'hFF;
            end else if (fill == FILL_ZEROS) begin
                tk.write_data = 8'h00;
            end
            tk.scl_sense = ($urandom_range(99) >= stretch_pct);
            if (bus_phase == PH_POLL && bus_role == ROLE_ACKCHK) begin
                tk.sda_sense = ($urandom_range(99) < nack_pct);
            end else if (fill == FILL_ONES) begin
                tk.sda_sense = 1'b1;
            end else if (fill == FILL_ZEROS) begin
                tk.sda_sense = 1'b0;
            end
            send_tick(tk);
            transaction_ticks++;
        end
    endtask

    task automatic run_transaction(input logic [1:0] cmd, input logic [6:0] addr,
                                   input logic [7:0] count, input int nack_pct,
                                   input int stretch_pct, input int busy_pct,
                                   input t_fill fill);
        begin_transaction(cmd, addr, count);
        drive_until_idle(nack_pct, stretch_pct, busy_pct, fill);
    endtask

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // idle engine ignores plain ticks whatever the other fields hold
    task automatic test_idle_after_reset();
        t_in_beat tk;
        tk = '1;
        tk.command = CMD_TICK;
        send_tick(tk);
        tk = '0;
        send_tick(tk);
        repeat (3) send_noise_tick();
    endtask

    // reset timing: the start condition waits the reset half period of 10,
    // and the first address bit is stretched until the reset poll limit of 100
    task automatic test_default_timing();
        t_in_beat tk;
        begin_transaction(CMD_WRITE_RSTART, 7'h7F, 8'd0);
        repeat (4) send_noise_tick();
        // shortened mid-wait: the running wait still counts down in full
        write_register(CFG_HALF_PERIOD, 16'd0);
        while (bus_phase != PH_IDLE) begin
            tk = IN_BITS'($urandom);
            tk.command = CMD_TICK;
            tk.scl_sense = !(bus_phase == PH_POLL && bus_role == ROLE_ADDR
                             && bit_pos == 4'd0);
            if (bus_phase == PH_POLL && bus_role == ROLE_ACKCHK) begin
                tk.sda_sense = 1'b0;
            end
            send_tick(tk);
            transaction_ticks++;
        end
    endtask

    // both sides run flat out through the two transactions of this test
    task automatic test_write_and_restart();
        write_register(CFG_HALF_PERIOD, 16'd0);
        write_register(CFG_STRETCH_LIMIT, 16'd1);
        no_idle = 1'b1;
        run_transaction(CMD_WRITE_STOP, 7'h00, 8'd2, 0, 0, 0, FILL_ZEROS);
        run_transaction(CMD_WRITE_RSTART, 7'h55, 8'd1, 0, 0, 0, FILL_ONES);
        no_idle = 1'b0;
    endtask

    // ack on every byte but the last, nack on the last
    task automatic test_read_ack_pattern();
        run_transaction(CMD_READ, 7'h2A, 8'd2, 0, 0, 0, FILL_RANDOM);
    endtask

    // address and ack check only, then the ending
    task automatic test_zero_bytes();
        run_transaction(CMD_READ, 7'h56, 8'd0, 0, 0, 0, FILL_RANDOM);
    endtask

    task automatic test_nack();
        // address not acknowledged
        run_transaction(CMD_WRITE_RSTART, 7'h52, 8'd2, 100, 0, 0, FILL_RANDOM);
        // nack at random among the address and data bytes
        run_transaction(CMD_WRITE_STOP, 7'h53, 8'd2, 50, 0, 0, FILL_RANDOM);
    endtask

    // stray commands on every busy beat must be ignored
    task automatic test_busy_commands();
        run_transaction(CMD_WRITE_STOP, 7'h3C, 8'd0, 0, 0, 100, FILL_RANDOM);
    endtask

    task automatic test_stretch_limits();
        // only the upper byte set: poll limit becomes zero, first low poll times out
        write_register(CFG_STRETCH_LIMIT, 16'hFF00);
        run_transaction(CMD_READ, 7'h44, 8'd0, 0, 50, 0, FILL_RANDOM);
        write_register(CFG_STRETCH_LIMIT, 16'd3);
        run_transaction(CMD_WRITE_STOP, 7'h46, 8'd0, 0, 60, 0, FILL_RANDOM);
    endtask

    task automatic test_register_edges();
        // writes to unused indexes change nothing
        for (int i = CFG_STRETCH_LIMIT + 1; i < 2 ** CFG_IDX_W; i++) begin
            write_register(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
        end
        run_transaction(CMD_READ, 7'h0F, 8'd0, 0, 20, 0, FILL_RANDOM);
    endtask

    // full byte count loaded, ended early by a nack
    task automatic test_long_transfers();
        run_transaction(CMD_WRITE_STOP, 7'h6B, 8'd255, 100, 0, 0, FILL_RANDOM);
        run_transaction(CMD_READ, 7'h6C, 8'd255, 100, 0, 0, FILL_RANDOM);
    endtask

    task automatic test_random_traffic();
        int start_ticks;
        bit paused;
        logic [1:0] cmd;
        logic [7:0] count;
        int nack_pct;
        int stretch_pct;
        t_fill fill;
        start_ticks = transaction_ticks;
        paused = 1'b0;
        while (transaction_ticks - start_ticks < RANDOM_TICKS) begin
            if ($urandom_range(99) < 30) begin
                write_register(CFG_HALF_PERIOD, ($urandom_range(99) < 80) ?
                               16'($urandom_range(0, 1)) : 16'($urandom_range(2, 3)));
            end
            if ($urandom_range(99) < 30) begin
                case ($urandom_range(3))
                    0: write_register(CFG_STRETCH_LIMIT, 16'd0);
                    1: write_register(CFG_STRETCH_LIMIT, 16'($urandom_range(1, 4)));
                    2: write_register(CFG_STRETCH_LIMIT, 16'hFFFF);
                    default: write_register(CFG_STRETCH_LIMIT, 16'($urandom_range(5, 254)));
                endcase
            end
            if ($urandom_range(99) < 20) begin
                repeat ($urandom_range(1, 4)) send_noise_tick();
            end
            // sender holds off until the bus side has caught up
            if (!paused && transaction_ticks - start_ticks >= RANDOM_TICKS / 2) begin
                settle();
                paused = 1'b1;
            end
            cmd = 2'($urandom_range(CMD_WRITE_STOP, CMD_READ));
            count = 8'($urandom_range(0, 2));
            nack_pct = ($urandom_range(99) < 70) ? 0 : int'($urandom_range(5, 60));
            stretch_pct = ($urandom_range(99) < 50) ? 0 : int'($urandom_range(10, 70));
            case ($urandom_range(9))
                0: fill = FILL_ONES;
                1: fill = FILL_ZEROS;
                default: fill = FILL_RANDOM;
            endcase
            run_transaction(cmd, 7'($urandom), count, nack_pct, stretch_pct,
                            int'($urandom_range(0, 30)), fill);
        end
    endtask

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------

    initial begin
        reset_engine();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_after_reset();
        test_default_timing();
        test_write_and_restart();
        test_read_ack_pattern();
        test_zero_bytes();
        test_nack();
        test_busy_commands();
        test_stretch_limits();
        test_register_edges();
        test_long_transfers();
        test_random_traffic();

        // drain, then give any stray beat time to show up
        settle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
+incdir+src
src/i2cmte_pkg.sv
src/i2cmte_step.sv
src/i2c_master_transaction_engine_unit.sv
test/tb.sv
